>>> rtl/rsi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types and constants of the radix string to integer unit.
// ----------------------------------------------------------------------------
package rsi_pkg;

	localparam int CHAR_W     = 8;
	localparam int VALUE_W    = 64;
	localparam int RADIX_W    = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int DIGIT_W    = 6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RADIX       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE   = 2'd2;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

	localparam logic [CHAR_W-1:0] CHAR_0       = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_9       = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2d;
	localparam logic [DIGIT_W-1:0] LETTER_BIAS = 6'd9;

	localparam logic [VALUE_W-1:0] MASK_NARROW = 64'h0000_0000_ffff_ffff;
	localparam logic [VALUE_W-1:0] MIN_WIDE    = 64'h8000_0000_0000_0000;
	localparam logic [VALUE_W-1:0] MIN_NARROW  = 64'h0000_0000_8000_0000;

	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		logic               signed_mode;
		logic               wide_mode;
	} cfg_t;

	// string state captured with the final item
	typedef struct packed {
		logic [VALUE_W-1:0] acc;
		logic               minus;
		logic               failed;
		logic               signed_mode;
		logic               wide_mode;
	} fin_t;

endpackage
`default_nettype wire

>>> rtl/rsi_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_in_if
// Character channel: at most one byte of the string per item.
// ----------------------------------------------------------------------------
interface rsi_in_if;
	import rsi_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              has_char;
	logic              end_of_string;

	modport source (output valid, output character, output has_char,
		output end_of_string, input ready);
	modport sink (input valid, input character, input has_char,
		input end_of_string, output ready);
endinterface
`default_nettype wire

>>> rtl/rsi_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_out_if
// Result channel: one converted integer per string.
// ----------------------------------------------------------------------------
interface rsi_out_if;
	import rsi_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic               bad_digit;

	modport source (output valid, output value, output bad_digit, input ready);
	modport sink (input valid, input value, input bad_digit, output ready);
endinterface
`default_nettype wire

>>> rtl/rsi_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rsi_cfg_if;
	import rsi_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/rsi_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_cfg_regs
// Configuration registers: radix, sign mode and result width.
// ----------------------------------------------------------------------------
module rsi_cfg_regs (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rsi_cfg_if.sink    cfg,
	output rsi_pkg::cfg_t regs
);
	import rsi_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.radix       <= RADIX_RESET;
			regs_q.signed_mode <= 1'b0;
			regs_q.wide_mode   <= 1'b1;
		end else if (cfg.valid) begin
			// writes beyond the register list are dropped
			unique case (cfg.index)
				CFG_RADIX:       regs_q.radix       <= cfg.data;
				CFG_SIGNED_MODE: regs_q.signed_mode <= cfg.data[0];
				CFG_WIDE_MODE:   regs_q.wide_mode   <= cfg.data[0];
				default:         regs_q             <= regs_q;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/rsi_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_accum
// Digit decode and per-string accumulator; captures the string state on the
// final item into the _s1 register.
// ----------------------------------------------------------------------------
module rsi_accum (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire rsi_pkg::cfg_t regs,
	rsi_in_if.sink        chars,
	output logic          fin_valid,
	input  wire logic     fin_ready,
	output rsi_pkg::fin_t fin
);
	import rsi_pkg::*;

	logic [VALUE_W-1:0] acc_q;
	logic               minus_q;
	logic               failed_q;
	logic               first_q;

	logic               valid_s1;
	fin_t               fin_s1;

	logic [RADIX_W-1:0] base;
	logic               is_num;
	logic               is_alpha;
	logic [DIGIT_W-1:0] dval;
	logic               digit_ok;
	logic               is_lead_minus;
	logic               accept;
	logic               s1_ready;

	logic [VALUE_W-1:0] acc_d;
	logic               minus_d;
	logic               failed_d;

	always_comb begin
		priority if (regs.radix < RADIX_MIN) base = RADIX_MIN;
		else if (regs.radix > RADIX_MAX)     base = RADIX_MAX;
		else                                 base = regs.radix;
	end

	assign is_num   = (chars.character >= CHAR_0) && (chars.character <= CHAR_9);
	assign is_alpha = ((chars.character >= CHAR_LOWER_A) && (chars.character <= CHAR_LOWER_Z))
		|| ((chars.character >= CHAR_UPPER_A) && (chars.character <= CHAR_UPPER_Z));
	assign dval     = is_num ? {2'b00, chars.character[3:0]}
		: ({1'b0, chars.character[4:0]} + LETTER_BIAS);
	assign digit_ok = (is_num || is_alpha) && (dval < base);
	assign is_lead_minus = first_q && regs.signed_mode && (chars.character == CHAR_MINUS);

	assign s1_ready    = !valid_s1 || fin_ready;
	assign chars.ready = s1_ready;
	assign accept      = chars.valid && s1_ready;

	always_comb begin
		acc_d    = acc_q;
		minus_d  = minus_q;
		failed_d = failed_q;
		if (chars.has_char && !failed_q) begin
			priority if (is_lead_minus) minus_d = 1'b1;
			else if (!digit_ok)         failed_d = 1'b1;
			else acc_d = acc_q * VALUE_W'(base) + VALUE_W'(dval);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			minus_q  <= 1'b0;
			failed_q <= 1'b0;
			first_q  <= 1'b1;
		end else if (accept) begin
			if (chars.end_of_string) begin
				// start the next string from a clean state
				acc_q    <= '0;
				minus_q  <= 1'b0;
				failed_q <= 1'b0;
				first_q  <= 1'b1;
			end else begin
				acc_q    <= acc_d;
				minus_q  <= minus_d;
				failed_q <= failed_d;
				if (chars.has_char) first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= accept && chars.end_of_string;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && chars.end_of_string) begin
			fin_s1.acc         <= acc_d;
			fin_s1.minus       <= minus_d;
			fin_s1.failed      <= failed_d;
			fin_s1.signed_mode <= regs.signed_mode;
			fin_s1.wide_mode   <= regs.wide_mode;
		end
	end

	assign fin_valid = valid_s1;
	assign fin       = fin_s1;
endmodule
`default_nettype wire

>>> rtl/rsi_finish.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_finish
// Sign, failure value and width masking of a finished string; holds the
// result in the output register.
// ----------------------------------------------------------------------------
module rsi_finish (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     fin_valid,
	output logic          fin_ready,
	input  wire rsi_pkg::fin_t fin,
	rsi_out_if.source     result
);
	import rsi_pkg::*;

	logic               valid_q;
	logic [VALUE_W-1:0] value_q;
	logic               bad_q;
	logic [VALUE_W-1:0] mask;
	logic [VALUE_W-1:0] value_d;
	logic               load;

	assign fin_ready = !valid_q || result.ready;
	assign load      = fin_valid && fin_ready;
	assign mask      = fin.wide_mode ? '1 : MASK_NARROW;

	always_comb begin
		priority if (fin.failed) begin
			if (fin.signed_mode) value_d = fin.wide_mode ? MIN_WIDE : MIN_NARROW;
			else                 value_d = mask;
		end else if (fin.minus) begin
			value_d = (-fin.acc) & mask;
		end else begin
			value_d = fin.acc & mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fin_ready) begin
			valid_q <= fin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= value_d;
			bad_q   <= fin.failed;
		end
	end

	assign result.valid     = valid_q;
	assign result.value     = value_q;
	assign result.bad_digit = bad_q;
endmodule
`default_nettype wire

>>> rtl/radix_string_to_integer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radix_string_to_integer_unit
// Converts a string of ASCII digits, at most one character per item, to an integer.
// ----------------------------------------------------------------------------
// The unit takes one character per clock cycle unless back-pressure holds
// it; the cycle is set by the accumulator loop, one 64 by 6 bit multiply
// and add per character. A string's result passes the _s1 register and
// then the output register after its final item is accepted; the next
// string may start while it is still in them. Radix values below 2 act as 2
// and above 36 as 36. Sign mode and result width are taken with the final
// item of each string; write configuration only while no string is in flight.
module radix_string_to_integer_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	rsi_in_if.sink    chars,
	rsi_out_if.source result,
	rsi_cfg_if.sink   cfg
);
	import rsi_pkg::*;

	cfg_t regs;
	fin_t fin;
	logic fin_valid;
	logic fin_ready;

	rsi_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	rsi_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.chars     (chars),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.fin       (fin)
	);

	rsi_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.fin       (fin),
		.result    (result)
	);
endmodule
`default_nettype wire
